/* hdl/memory_region_registration_table_defines.svh */
// assertion macros used by the region table sequencer
`ifndef MEMORY_REGION_REGISTRATION_TABLE_DEFINES_SVH
`define MEMORY_REGION_REGISTRATION_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define MRRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MRRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MRRT_ASSERT(lbl, prop, msg)
`define MRRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/mrrt_pkg.sv */
// shared types and constants of the region registration table
package mrrt_pkg;

  localparam int MRRT_TABLE_ENTRIES = 16;
  localparam int MAX_RESULTS        = 16;
  localparam int BW                 = $clog2(MAX_RESULTS);

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NOT_COVERED = 2'd1;
  localparam logic [1:0] STATUS_FULL        = 2'd2;

  typedef struct packed {
    logic [47:0] base;
    logic [47:0] length;
    logic [7:0]  location;
    logic [15:0] refs;
  } mrrt_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    mrrt_entry_t ent;
    logic        changed;
    logic        last;
  } mrrt_result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_Q_RD, ST_Q_CHK, ST_Q_ERD, ST_Q_EMIT,
    ST_A_RD, ST_A_CHK, ST_U_RD, ST_U_WR, ST_A_NEW,
    ST_R_RD, ST_R_CHK, ST_D_RD, ST_D_WR, ST_RESP
  } mrrt_state_t;

endpackage

/* hdl/mrrt_if.sv */
// input and result channel interfaces
interface mrrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [47:0] base;
  logic [47:0] length;
  logic [7:0]  location_tag;
  modport source (output valid, op, base, length, location_tag, input ready);
  modport sink (input valid, op, base, length, location_tag, output ready);
endinterface

interface mrrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] entry_base;
  logic [47:0] entry_length;
  logic [7:0]  entry_location;
  logic [15:0] entry_refs;
  logic        changed;
  logic        last;
  modport source (output valid, status, entry_base, entry_length, entry_location,
                  entry_refs, changed, last, input ready);
  modport sink (input valid, status, entry_base, entry_length, entry_location,
                entry_refs, changed, last, output ready);
endinterface

/* hdl/memory_region_registration_table.sv */
// Memory region registration table with reference counts.
// in_if carries one operation per transfer (op, base, length, location_tag):
// query coverage, add region or remove region; op 3 is dropped with no result.
// out_if carries result transfers; last marks the final one of an operation.
// A query yields the chain of covering regions, or one not-covered result.
// Add and remove yield exactly one result each.
// Entries sit in a single-port-read memory, scanned one entry at a time
// (address, then compare on the registered read data); inserts and releases
// shift later entries one at a time (read, then write). An insert ahead of
// existing entries shifts them before the new entry is written. A query
// rescans the table for each chain link and then reads back each result, so
// the table scan sets the rate. Each new operation is taken from idle.
// A new operation is taken only when the previous one has finished; the last
// result may still sit in the output register while the next one is taken.
// If the receiver stalls, the sequencer holds until the output register frees.
// Synchronous reset empties the table (count to zero) and drops any result;
// no clearing pass is needed, so operations are taken right after reset.
module memory_region_registration_table import mrrt_pkg::*; #(
  parameter int TABLE_ENTRIES = MRRT_TABLE_ENTRIES,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input logic        clk,
  input logic        rst_n,
  mrrt_in_if.sink    in_if,
  mrrt_out_if.source out_if
);

  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  mrrt_entry_t   rd_data, wr_data;

  // entry storage
  mrrt_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // operation sequencer
  mrrt_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

/* hdl/mrrt_mem.sv */
// region entry memory, one write port and one registered read port
module mrrt_mem import mrrt_pkg::*; #(
  parameter int TABLE_ENTRIES = MRRT_TABLE_ENTRIES,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic        clk,
  input  logic [IW-1:0] rd_addr,
  output mrrt_entry_t rd_data,
  input  logic        wr_en,
  input  logic [IW-1:0] wr_addr,
  input  mrrt_entry_t wr_data
);

  mrrt_entry_t mem [TABLE_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/mrrt_ctrl.sv */
// sequencer that scans, updates and shifts the sorted region table
`include "memory_region_registration_table_defines.svh"
module mrrt_ctrl import mrrt_pkg::*; #(
  parameter int TABLE_ENTRIES = MRRT_TABLE_ENTRIES,
  localparam int IW = $clog2(TABLE_ENTRIES),
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  mrrt_in_if.sink       in_if,
  mrrt_out_if.source    out_if,
  output logic [IW-1:0] rd_addr,
  input  mrrt_entry_t   rd_data,
  output logic          wr_en,
  output logic [IW-1:0] wr_addr,
  output mrrt_entry_t   wr_data
);

  mrrt_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, idx_r, i_r, pos_r;
  logic         pos_found_r;
  logic [47:0]  base_r, len_r;
  logic [7:0]   loc_r;
  logic [48:0]  cur_r, end_r;
  logic [BW:0]  n_r, ei_r;
  logic [IW-1:0] chain_r [MAX_RESULTS];
  mrrt_result_t res_r, out_r;
  logic         out_valid_r;

  logic         in_xfer, slot_free, push;
  logic [CW-1:0] idx_inc, i_inc, i_dec, a_pos;
  logic         last_scan, q_hit, a_match, a_before, r_match, emit_last;
  logic [48:0]  ent_end;
  logic [15:0]  r_refs, a_refs;
  mrrt_entry_t  ent, new_ent, a_ent, r_ent;

  // compare terms on the entry just read
  always_comb begin
    ent       = rd_data;
    ent_end   = {1'b0, ent.base} + {1'b0, ent.length};
    idx_inc   = idx_r + CW'(1);
    i_inc     = i_r + CW'(1);
    i_dec     = i_r - CW'(1);
    last_scan = (idx_inc == count_r);
    q_hit     = ({1'b0, ent.base} <= cur_r) && (ent_end > cur_r);
    a_match   = (ent.base == base_r) && (ent.length == len_r);
    a_before  = (base_r < ent.base) || ((base_r == ent.base) && (len_r > ent.length));
    a_pos     = pos_found_r ? pos_r : (a_before ? idx_r : count_r);
    r_match   = (ent.base == base_r) && ((len_r == '0) || (ent.length == len_r));
    r_refs    = (ent.refs != '0) ? ent.refs - 16'd1 : 16'd0;
    a_refs    = (ent.refs != 16'hFFFF) ? ent.refs + 16'd1 : ent.refs;
    a_ent     = '{base: ent.base, length: ent.length, location: ent.location, refs: a_refs};
    r_ent     = '{base: ent.base, length: ent.length, location: ent.location, refs: r_refs};
    emit_last = ((ei_r + (BW+1)'(1)) == n_r);
    new_ent   = '{base: base_r, length: len_r, location: loc_r, refs: 16'd1};
    slot_free = !out_valid_r || out_if.ready;
    in_xfer   = in_if.valid && in_if.ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_if.op)
            OP_QUERY:  state_nxt = (count_r == '0) ? ST_RESP : ST_Q_RD;
            OP_ADD:    state_nxt = (count_r == '0) ? ST_A_NEW : ST_A_RD;
            OP_REMOVE: state_nxt = (count_r == '0) ? ST_RESP : ST_R_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_Q_RD:  state_nxt = ST_Q_CHK;
      ST_Q_CHK: begin
        if (q_hit) begin
          if (n_r == (BW+1)'(MAX_RESULTS)) state_nxt = ST_RESP;
          else if (ent_end >= end_r)       state_nxt = ST_Q_ERD;
          else                             state_nxt = ST_Q_RD;
        end else begin
          state_nxt = last_scan ? ST_RESP : ST_Q_RD;
        end
      end
      ST_Q_ERD:  state_nxt = ST_Q_EMIT;
      ST_Q_EMIT: begin
        if (slot_free) state_nxt = emit_last ? ST_IDLE : ST_Q_ERD;
      end
      ST_A_RD:  state_nxt = ST_A_CHK;
      ST_A_CHK: begin
        if (a_match) state_nxt = ST_RESP;
        else if (last_scan) begin
          if (count_r >= CW'(TABLE_ENTRIES)) state_nxt = ST_RESP;
          else if (a_pos == count_r)         state_nxt = ST_A_NEW;
          else                               state_nxt = ST_U_RD;
        end else begin
          state_nxt = ST_A_RD;
        end
      end
      ST_U_RD:  state_nxt = ST_U_WR;
      ST_U_WR:  state_nxt = (i_dec == pos_r) ? ST_A_NEW : ST_U_RD;
      ST_A_NEW: state_nxt = ST_RESP;
      ST_R_RD:  state_nxt = ST_R_CHK;
      ST_R_CHK: begin
        if (r_match) begin
          if (r_refs != '0 || last_scan) state_nxt = ST_RESP;
          else                           state_nxt = ST_D_RD;
        end else begin
          state_nxt = last_scan ? ST_RESP : ST_R_RD;
        end
      end
      ST_D_RD: state_nxt = ST_D_WR;
      ST_D_WR: state_nxt = ((i_r + CW'(2)) == count_r) ? ST_RESP : ST_D_RD;
      ST_RESP: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    rd_addr     = idx_r[IW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_r[IW-1:0];
    wr_data     = ent;
    in_if.ready = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_if.ready = 1'b1;
      ST_Q_ERD,
      ST_Q_EMIT: begin
        rd_addr = chain_r[ei_r[BW-1:0]];
        push    = (state_r == ST_Q_EMIT) && slot_free;
      end
      ST_A_CHK: begin
        if (a_match) begin
          wr_en   = 1'b1;
          wr_data = a_ent;
        end
      end
      ST_U_RD: rd_addr = i_dec[IW-1:0];
      ST_U_WR: begin
        wr_en   = 1'b1;
        wr_addr = i_r[IW-1:0];
      end
      ST_A_NEW: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[IW-1:0];
        wr_data = new_ent;
      end
      ST_R_CHK: begin
        if (r_match && r_refs != '0) begin
          wr_en   = 1'b1;
          wr_data = r_ent;
        end
      end
      ST_D_RD: rd_addr = i_inc[IW-1:0];
      ST_D_WR: begin
        wr_en   = 1'b1;
        wr_addr = i_r[IW-1:0];
      end
      ST_RESP: push = slot_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_A_NEW) count_r <= count_r + CW'(1);
      if (state_r == ST_R_CHK && r_match && r_refs == '0 && last_scan)
        count_r <= count_r - CW'(1);
      if (state_r == ST_D_WR && (i_r + CW'(2)) == count_r)
        count_r <= count_r - CW'(1);
      if (push)              out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // operation datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        base_r      <= in_if.base;
        len_r       <= in_if.length;
        loc_r       <= in_if.location_tag;
        cur_r       <= {1'b0, in_if.base};
        end_r       <= {1'b0, in_if.base} + {1'b0, in_if.length};
        idx_r       <= '0;
        n_r         <= '0;
        ei_r        <= '0;
        pos_r       <= count_r;
        i_r         <= count_r;
        pos_found_r <= 1'b0;
        res_r       <= '{status: (in_if.op == OP_QUERY) ? STATUS_NOT_COVERED : STATUS_OK,
                         ent: '0, changed: 1'b0, last: 1'b1};
      end
      ST_Q_CHK: begin
        if (q_hit) begin
          if (n_r != (BW+1)'(MAX_RESULTS)) begin
            chain_r[n_r[BW-1:0]] <= idx_r[IW-1:0];
            n_r   <= n_r + (BW+1)'(1);
            cur_r <= ent_end;
            idx_r <= '0;
          end
        end else begin
          idx_r <= idx_inc;
        end
      end
      ST_Q_EMIT: begin
        if (slot_free) ei_r <= ei_r + (BW+1)'(1);
      end
      ST_A_CHK: begin
        if (a_match) begin
          res_r <= '{status: res_r.status, ent: a_ent, changed: 1'b0, last: 1'b1};
        end else begin
          pos_r       <= a_pos;
          pos_found_r <= pos_found_r || a_before;
          idx_r       <= idx_inc;
          if (last_scan && count_r >= CW'(TABLE_ENTRIES)) res_r.status <= STATUS_FULL;
        end
      end
      ST_U_WR: i_r <= i_dec;
      ST_A_NEW: begin
        res_r <= '{status: res_r.status, ent: new_ent, changed: 1'b1, last: 1'b1};
      end
      ST_R_CHK: begin
        if (r_match) begin
          res_r <= '{status: res_r.status, ent: r_ent, changed: (r_refs == '0),
                     last: 1'b1};
          i_r   <= idx_r;
        end
        idx_r <= idx_inc;
      end
      ST_D_WR: i_r <= i_inc;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (push) begin
      if (state_r == ST_Q_EMIT) begin
        out_r <= '{status: STATUS_OK, ent: ent, changed: 1'b0, last: emit_last};
      end else begin
        out_r <= res_r;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_r.status;
  assign out_if.entry_base     = out_r.ent.base;
  assign out_if.entry_length   = out_r.ent.length;
  assign out_if.entry_location = out_r.ent.location;
  assign out_if.entry_refs     = out_r.ent.refs;
  assign out_if.changed        = out_r.changed;
  assign out_if.last           = out_r.last;

  `MRRT_ASSERT(a_count_bound, count_r <= CW'(TABLE_ENTRIES), "region count above table size")
  `MRRT_ASSERT(a_no_write_idle, (state_r != ST_IDLE) || !wr_en, "table write while idle")
  `MRRT_ASSERT(a_chain_bound, n_r <= (BW+1)'(MAX_RESULTS), "query chain too long")
  `MRRT_ASSERT_NEXT(a_insert_grows, state_r == ST_A_NEW, count_r == $past(count_r) + CW'(1), "no growth")

endmodule
